FILE: sv/olte_pkg.sv
// Shared types and codes for the ordered list table engine.
// No dependencies; imported by the interfaces, the cell and the top level.
`default_nettype none

package olte_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT_FRONT = 2'd0,
        ACT_INSERT_BACK  = 2'd1,
        ACT_REMOVE       = 2'd2,
        ACT_LOOKUP       = 2'd3
    } olte_action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } olte_status_t;

    localparam int unsigned ValueWidth  = 32;
    localparam int unsigned LengthWidth = 5;

    // Broadcast command seen by every cell in the chain.
    typedef struct packed {
        logic                  front;
        logic                  tail;
        logic                  remove;
        logic [ValueWidth-1:0] value;
    } olte_cmd_t;

endpackage

`default_nettype wire

FILE: sv/olte_req_if.sv
// Request channel of the ordered list table engine: valid/ready plus action and value.
// Depends on olte_pkg for field widths.
`default_nettype none

interface olte_req_if
    import olte_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic signed [ValueWidth-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

FILE: sv/olte_rsp_if.sv
// Response channel of the ordered list table engine: valid/ready plus result fields.
// Depends on olte_pkg for field widths.
`default_nettype none

interface olte_rsp_if
    import olte_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic                          found;
    logic [LengthWidth-1:0]        length;
    logic signed [ValueWidth-1:0]  even_sum;

    modport source (output valid, output status, output found, output length,
                    output even_sum, input ready);
    modport sink   (input valid, input status, input found, input length,
                    input even_sum, output ready);
endinterface

`default_nettype wire

FILE: sv/olte_cell.sv
// One storage cell of the list: holds one element, matches it against the
// broadcast value and shifts from its neighbors. Depends on olte_pkg.
`default_nettype none

module olte_cell
    import olte_pkg::*;
(
    input  wire logic                  clk,
    input  wire olte_cmd_t             cmd,
    input  wire logic                  occupied,
    input  wire logic                  at_tail,
    input  wire logic [ValueWidth-1:0] left_val,
    input  wire logic [ValueWidth-1:0] right_val,
    input  wire logic                  seen_in,
    output logic                       seen_out,
    output logic [ValueWidth-1:0]      val
);

    logic [ValueWidth-1:0] val_reg;
    logic [ValueWidth-1:0] val_next;
    logic                  hit;

    assign hit      = occupied && (val_reg == cmd.value);
    assign seen_out = seen_in || hit;
    assign val      = val_reg;

    always_comb
    begin
        priority if (cmd.front)
        begin
            val_next = left_val;
        end
        else if (cmd.tail && at_tail)
        begin
            val_next = cmd.value;
        end
        else if (cmd.remove && seen_out)
        begin
            val_next = right_val;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

FILE: sv/ordered_list_table_engine.sv
// Ordered list table engine: a bounded list of up to DEPTH signed 32-bit values
// held in a chain of cells, front at cell 0. Each request inserts at the front,
// inserts at the back, removes the first match or looks a value up, and yields
// one response with status, found, element count and wrapping sum of even
// elements. One request is taken per clock: all cells compare against the value
// and shift in the same cycle, and the response sits in an output register, so
// a new request is accepted whenever that register is empty or being drained.
// The found chain ripples through DEPTH cells and sets the critical path.
// Depends on olte_pkg, olte_req_if, olte_rsp_if and olte_cell.
`default_nettype none

module ordered_list_table_engine
    import olte_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    olte_req_if.sink    req,
    olte_rsp_if.source  rsp
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [ValueWidth-1:0]   sum_reg;
    logic [ValueWidth-1:0]   sum_next;
    logic                    out_valid_reg;
    logic [1:0]              status_reg;
    logic [1:0]              status_next;
    logic                    found_reg;
    logic [LengthWidth-1:0]  length_reg;
    logic [ValueWidth-1:0]   even_sum_reg;
    logic [CW+LengthWidth-1:0] count_wide;

    logic                    accept;
    logic                    full;
    logic                    is_insert;
    logic                    is_remove;
    logic                    is_lookup;
    logic                    even;
    logic                    found;
    logic [ValueWidth-1:0]   in_value;
    olte_cmd_t               cell_cmd;

    logic [ValueWidth-1:0]   cell_val [DEPTH];
    logic [DEPTH:0]          seen;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign in_value  = req.value;
    assign full      = (count_reg == CW'(DEPTH));
    assign is_insert = (req.action == ACT_INSERT_FRONT) || (req.action == ACT_INSERT_BACK);
    assign is_remove = (req.action == ACT_REMOVE);
    assign is_lookup = (req.action == ACT_LOOKUP);
    assign even      = !in_value[0];
    assign found     = seen[DEPTH];

    assign cell_cmd.front  = accept && (req.action == ACT_INSERT_FRONT) && !full;
    assign cell_cmd.tail   = accept && (req.action == ACT_INSERT_BACK) && !full;
    assign cell_cmd.remove = accept && is_remove;
    assign cell_cmd.value  = in_value;

    assign seen[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        logic [ValueWidth-1:0] left_val;
        logic [ValueWidth-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = in_value;
        end
        else
        begin : g_mid_left
            assign left_val = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_val = cell_val[i];
        end
        else
        begin : g_mid_right
            assign right_val = cell_val[i+1];
        end

        olte_cell u_cell (
            .clk       (clk),
            .cmd       (cell_cmd),
            .occupied  (IDX < count_reg),
            .at_tail   (IDX == count_reg),
            .left_val  (left_val),
            .right_val (right_val),
            .seen_in   (seen[i]),
            .seen_out  (seen[i+1]),
            .val       (cell_val[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        sum_next    = sum_reg;
        status_next = ST_OK;
        priority if (is_insert)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
                if (even)
                begin
                    sum_next = sum_reg + in_value;
                end
            end
        end
        else if (is_remove)
        begin
            if (!found)
            begin
                status_next = ST_NOT_FOUND;
            end
            else
            begin
                count_next = count_reg - CW'(1);
                if (even)
                begin
                    sum_next = sum_reg - in_value;
                end
            end
        end
        else
        begin
            if (!found)
            begin
                status_next = ST_NOT_FOUND;
            end
        end
    end

    assign count_wide = {{LengthWidth{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                sum_reg       <= sum_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            found_reg    <= found;
            length_reg   <= count_wide[LengthWidth-1:0];
            even_sum_reg <= sum_next;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = status_reg;
    assign rsp.found    = found_reg;
    assign rsp.length   = length_reg;
    assign rsp.even_sum = even_sum_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count exceeds depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_insert && full |=> count_reg == $past(count_reg))
        else $error("insert into full store changed count");

    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_remove && found |=> count_reg == $past(count_reg) - CW'(1))
        else $error("successful remove did not decrement count");

    a_lookup_keep: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_lookup |=> count_reg == $past(count_reg) && sum_reg == $past(sum_reg))
        else $error("lookup changed list state");

    a_miss_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_NOT_FOUND |-> !found_reg)
        else $error("not-found response reports a hit");

endmodule

`default_nettype wire
